// File: rtl/dag_topological_sort_macros.svh
// ----------------------------------------------------------------------------
// DAG topological sorter assertion macros
// Concurrent assertion helpers used by the sorter's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef DAG_TOPOLOGICAL_SORT_MACROS_SVH
`define DAG_TOPOLOGICAL_SORT_MACROS_SVH

`ifndef SYNTHESIS
// Checks that a condition holds at every clock edge outside reset.
`define DTS_ASSERT(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
    else $error("dag_topological_sort: assertion failed");
// Checks that a consequent holds in the same cycle as its antecedent.
`define DTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("dag_topological_sort: implication failed");
`else
`define DTS_ASSERT(lbl, clk, rst_n, cond)
`define DTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/dts_pkg.sv
// ----------------------------------------------------------------------------
// DAG topological sorter package
// Sizes, payload types, opcodes, memory request structs and helper functions.
// ----------------------------------------------------------------------------
package dts_pkg;

  localparam int MaxVertices = 64;
  localparam int VertexW     = $clog2(MaxVertices);
  localparam int CountW      = $clog2(MaxVertices + 1);

  typedef logic [VertexW-1:0]     vertex_t;
  typedef logic [CountW-1:0]      count_t;
  typedef logic [MaxVertices-1:0] row_t;

  localparam count_t NumVerticesReset = count_t'(MaxVertices);

  typedef enum logic [1:0] {
    OpAddEdge = 2'd0,
    OpSort    = 2'd1,
    OpClear   = 2'd2
  } opcode_e;

  typedef struct packed {
    logic    rd_en;
    vertex_t rd_addr;
    logic    wr_en;
    vertex_t wr_addr;
    row_t    wr_data;
    logic    clear;
  } adj_req_t;

  typedef struct packed {
    logic    rd_en;
    vertex_t rd_addr;
    logic    wr_en;
    vertex_t wr_addr;
    vertex_t wr_data;
  } stk_req_t;

  // Bits below n set, all others clear.
  function automatic row_t mask_below(input count_t n);
    row_t m;
    for (int i = 0; i < MaxVertices; i++) begin
      m[i] = (count_t'(i) < n);
    end
    return m;
  endfunction

  // Index of the lowest set bit, zero when none is set.
  function automatic vertex_t first_set(input row_t r);
    vertex_t idx;
    idx = '0;
    for (int i = MaxVertices - 1; i >= 0; i--) begin
      if (r[i]) begin
        idx = vertex_t'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: rtl/dts_if.sv
// ----------------------------------------------------------------------------
// DAG topological sorter channels
// Command channel into the sorter and order channel out of it.
// ----------------------------------------------------------------------------
interface dts_in_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           opcode;
  dts_pkg::vertex_t     src_vertex;
  dts_pkg::vertex_t     dst_vertex;

  modport source (output valid, output opcode, output src_vertex, output dst_vertex,
                  input ready);
  modport sink   (input valid, input opcode, input src_vertex, input dst_vertex,
                  output ready);
endinterface

interface dts_out_if;
  logic                 valid;
  logic                 ready;
  dts_pkg::vertex_t     order_vertex;
  logic                 is_last;

  modport source (output valid, output order_vertex, output is_last, input ready);
  modport sink   (input valid, input order_vertex, input is_last, output ready);
endinterface

// File: rtl/dts_adj_mem.sv
// ----------------------------------------------------------------------------
// Adjacency matrix memory
// One row per source vertex, registered read, per-row valid bits for clearing.
// ----------------------------------------------------------------------------
module dts_adj_mem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dts_pkg::adj_req_t req_i,
  output dts_pkg::row_t     rd_data_o
);

  dts_pkg::row_t                       mem_q [dts_pkg::MaxVertices];
  dts_pkg::row_t                       rdata_q;
  logic [dts_pkg::MaxVertices-1:0]     valid_q;
  logic                                rvalid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
    end
  end

  // A row that was never written since reset or the last clear reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rvalid_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

// File: rtl/dts_stack_mem.sv
// ----------------------------------------------------------------------------
// Search and finish stack memory
// Search frames grow from the bottom, finished vertices from the top.
// ----------------------------------------------------------------------------
module dts_stack_mem (
  input  logic              clk_i,
  input  dts_pkg::stk_req_t req_i,
  output dts_pkg::vertex_t  rd_data_o
);

  dts_pkg::vertex_t mem_q [dts_pkg::MaxVertices];
  dts_pkg::vertex_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rdata_q;

endmodule

// File: rtl/dag_topological_sort.sv
// ----------------------------------------------------------------------------
// DAG topological sorter
// Holds a directed graph as an adjacency bit matrix and emits its vertices
// in reverse depth-first finishing order.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake         Payload
//  item_i    in         valid/ready       opcode, src_vertex, dst_vertex
//  order_o   out        valid/ready       order_vertex, is_last
//  cfg       in         cfg_we_i only     cfg_wdata_i (num_vertices)
//
//  An add-edge transaction reads the source row, then writes it back with
//  the new edge bit set; a clear is taken in the idle state. A sort runs a
//  depth-first search over the n vertices in use, then reads each finished
//  vertex from the stack memory and loads it into the output register.
//  Reset needs no clearing pass: per-row valid bits empty the matrix at once.
//  A stalled order_o holds the emitter; no new command is taken until the
//  last vertex of a sort has been loaded into the output register.
//
`include "dag_topological_sort_macros.svh"

module dag_topological_sort (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  dts_in_if.sink                 item_i,
  dts_out_if.source              order_o,
  input  logic                   cfg_we_i,
  input  dts_pkg::count_t        cfg_wdata_i
);

  localparam logic [2:0] StIdle     = 3'd0;
  localparam logic [2:0] StAddWr    = 3'd1;
  localparam logic [2:0] StRoot     = 3'd2;
  localparam logic [2:0] StScan     = 3'd3;
  localparam logic [2:0] StPop      = 3'd4;
  localparam logic [2:0] StEmitRd   = 3'd5;
  localparam logic [2:0] StEmitWait = 3'd6;

  logic [2:0]        state_q, state_d;
  dts_pkg::count_t   num_q;
  dts_pkg::count_t   n_q, n_d;
  dts_pkg::row_t     mask_q, mask_d;
  dts_pkg::row_t     visited_q, visited_d;
  dts_pkg::count_t   root_q, root_d;
  dts_pkg::count_t   depth_q, depth_d;
  dts_pkg::count_t   fin_q, fin_d;
  dts_pkg::vertex_t  top_q, top_d;
  dts_pkg::vertex_t  emit_addr_q, emit_addr_d;
  dts_pkg::vertex_t  add_src_q, add_src_d;
  dts_pkg::vertex_t  add_dst_q, add_dst_d;
  logic              out_valid_q, out_valid_d;
  dts_pkg::vertex_t  out_vertex_q, out_vertex_d;
  logic              out_last_q, out_last_d;

  dts_pkg::adj_req_t adj_req;
  dts_pkg::row_t     adj_rdata;
  dts_pkg::stk_req_t stk_req;
  dts_pkg::vertex_t  stk_rdata;

  dts_pkg::count_t   n_sat;
  dts_pkg::count_t   depth_m2;
  dts_pkg::row_t     cand;
  dts_pkg::vertex_t  child;
  dts_pkg::vertex_t  root_v;
  logic              accept;
  logic              out_free;

  logic                     in_search;
  logic [dts_pkg::CountW:0] used_slots;
  logic                     roots_seen;

  dts_adj_mem u_adj_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (adj_req),
    .rd_data_o (adj_rdata)
  );

  dts_stack_mem u_stack_mem (
    .clk_i     (clk_i),
    .req_i     (stk_req),
    .rd_data_o (stk_rdata)
  );

  assign item_i.ready = (state_q == StIdle);
  assign accept       = item_i.valid && item_i.ready;
  assign out_free     = !out_valid_q || order_o.ready;

  // A register value above the matrix size is treated as the full size.
  assign n_sat    = (num_q > dts_pkg::NumVerticesReset) ? dts_pkg::NumVerticesReset : num_q;
  assign depth_m2 = depth_q - dts_pkg::count_t'(2);
  assign root_v   = root_q[dts_pkg::VertexW-1:0];

  // Successors of the vertex on top of the stack that are in use and unvisited.
  // Rescanning from zero after a pop finds the same next successor as resuming,
  // since the visited set only grows during a sort.
  assign cand  = adj_rdata & ~visited_q & mask_q;
  assign child = dts_pkg::first_set(cand);

  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    mask_d       = mask_q;
    visited_d    = visited_q;
    root_d       = root_q;
    depth_d      = depth_q;
    fin_d        = fin_q;
    top_d        = top_q;
    emit_addr_d  = emit_addr_q;
    add_src_d    = add_src_q;
    add_dst_d    = add_dst_q;
    out_valid_d  = out_valid_q;
    out_vertex_d = out_vertex_q;
    out_last_d   = out_last_q;
    adj_req      = '0;
    stk_req      = '0;

    if (out_valid_q && order_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          case (item_i.opcode)
            dts_pkg::OpAddEdge: begin
              // Vertex fields are exactly as wide as the matrix, so every
              // edge is in range and gets stored.
              adj_req.rd_en   = 1'b1;
              adj_req.rd_addr = item_i.src_vertex;
              add_src_d       = item_i.src_vertex;
              add_dst_d       = item_i.dst_vertex;
              state_d         = StAddWr;
            end
            dts_pkg::OpSort: begin
              n_d       = n_sat;
              mask_d    = dts_pkg::mask_below(n_sat);
              visited_d = '0;
              fin_d     = '0;
              depth_d   = '0;
              root_d    = '0;
              if (n_sat != '0) begin
                state_d = StRoot;
              end
            end
            dts_pkg::OpClear: begin
              adj_req.clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      StAddWr: begin
        adj_req.wr_en   = 1'b1;
        adj_req.wr_addr = add_src_q;
        adj_req.wr_data = adj_rdata | (dts_pkg::row_t'(1) << add_dst_q);
        state_d         = StIdle;
      end

      StRoot: begin
        if (root_q == n_q) begin
          // Every vertex is finished; the finish entries sit at the top of
          // the stack memory, the last finished one lowest.
          emit_addr_d = dts_pkg::vertex_t'(dts_pkg::NumVerticesReset - n_q);
          state_d     = StEmitRd;
        end else if (visited_q[root_v]) begin
          root_d = root_q + dts_pkg::count_t'(1);
        end else begin
          visited_d[root_v] = 1'b1;
          top_d             = root_v;
          stk_req.wr_en     = 1'b1;
          stk_req.wr_addr   = '0;
          stk_req.wr_data   = root_v;
          depth_d           = dts_pkg::count_t'(1);
          adj_req.rd_en     = 1'b1;
          adj_req.rd_addr   = root_v;
          root_d            = root_q + dts_pkg::count_t'(1);
          state_d           = StScan;
        end
      end

      StScan: begin
        if (cand != '0) begin
          // Descend into the lowest unvisited successor.
          visited_d[child] = 1'b1;
          stk_req.wr_en    = 1'b1;
          stk_req.wr_addr  = depth_q[dts_pkg::VertexW-1:0];
          stk_req.wr_data  = child;
          depth_d          = depth_q + dts_pkg::count_t'(1);
          top_d            = child;
          adj_req.rd_en    = 1'b1;
          adj_req.rd_addr  = child;
        end else begin
          // The top vertex is finished. Search frames plus finished vertices
          // never exceed the vertex count, so the two regions never meet.
          stk_req.wr_en   = 1'b1;
          stk_req.wr_addr = ~fin_q[dts_pkg::VertexW-1:0];
          stk_req.wr_data = top_q;
          fin_d           = fin_q + dts_pkg::count_t'(1);
          depth_d         = depth_q - dts_pkg::count_t'(1);
          if (depth_q == dts_pkg::count_t'(1)) begin
            state_d = StRoot;
          end else begin
            stk_req.rd_en   = 1'b1;
            stk_req.rd_addr = depth_m2[dts_pkg::VertexW-1:0];
            state_d         = StPop;
          end
        end
      end

      StPop: begin
        top_d           = stk_rdata;
        adj_req.rd_en   = 1'b1;
        adj_req.rd_addr = stk_rdata;
        state_d         = StScan;
      end

      StEmitRd: begin
        stk_req.rd_en   = 1'b1;
        stk_req.rd_addr = emit_addr_q;
        state_d         = StEmitWait;
      end

      StEmitWait: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_vertex_d = stk_rdata;
          out_last_d   = (emit_addr_q == '1);
          if (emit_addr_q == '1) begin
            state_d = StIdle;
          end else begin
            emit_addr_d = emit_addr_q + dts_pkg::vertex_t'(1);
            state_d     = StEmitRd;
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      num_q       <= dts_pkg::NumVerticesReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        num_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q          <= n_d;
    mask_q       <= mask_d;
    visited_q    <= visited_d;
    root_q       <= root_d;
    depth_q      <= depth_d;
    fin_q        <= fin_d;
    top_q        <= top_d;
    emit_addr_q  <= emit_addr_d;
    add_src_q    <= add_src_d;
    add_dst_q    <= add_dst_d;
    out_vertex_q <= out_vertex_d;
    out_last_q   <= out_last_d;
  end

  assign order_o.valid        = out_valid_q;
  assign order_o.order_vertex = out_vertex_q;
  assign order_o.is_last      = out_last_q;

  // Terms that the checks below compare.
  assign in_search  = (state_q == StScan) || (state_q == StPop);
  assign used_slots = {1'b0, depth_q} + {1'b0, fin_q};
  assign roots_seen = ((visited_q & dts_pkg::mask_below(root_q)) ==
                       dts_pkg::mask_below(root_q));

  `DTS_ASSERT_IMPL(a_stack_fits, clk_i, rst_ni, in_search, (used_slots <= {1'b0, n_q}))
  `DTS_ASSERT_IMPL(a_scan_has_frame, clk_i, rst_ni, (state_q == StScan), (depth_q != '0))
  `DTS_ASSERT_IMPL(a_all_finished, clk_i, rst_ni, (state_q == StEmitRd), (fin_q == n_q))
  `DTS_ASSERT_IMPL(a_roots_visited, clk_i, rst_ni, (state_q == StRoot), roots_seen)

endmodule
